// ===== src/slc_pkg.sv =====
// Shared types and constants for the source line classifier.
// No dependencies; imported by every module of the block.
package slc_pkg;

    localparam int COUNT_WIDTH_DEF = 32;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int OUT_WIDTH       = 32;
    localparam int OUT_FIELDS      = 7;
    localparam int BYTE_WIDTH      = 8;

    // Item kinds carried on s_tuser
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_EOF  = 1'b1;

    // Characters the lexer reacts to
    localparam logic [BYTE_WIDTH-1:0] CH_QUOTE  = 8'h22;
    localparam logic [BYTE_WIDTH-1:0] CH_APOS   = 8'h27;
    localparam logic [BYTE_WIDTH-1:0] CH_SLASH  = 8'h2F;
    localparam logic [BYTE_WIDTH-1:0] CH_STAR   = 8'h2A;
    localparam logic [BYTE_WIDTH-1:0] CH_BSLASH = 8'h5C;
    localparam logic [BYTE_WIDTH-1:0] CH_NL     = 8'h0A;
    localparam logic [BYTE_WIDTH-1:0] CH_SPACE  = 8'h20;
    localparam logic [BYTE_WIDTH-1:0] CH_TAB    = 8'h09;
    localparam logic [BYTE_WIDTH-1:0] CH_VT     = 8'h0B;
    localparam logic [BYTE_WIDTH-1:0] CH_FF     = 8'h0C;
    localparam logic [BYTE_WIDTH-1:0] CH_CR     = 8'h0D;

    // Classification of a finished line
    typedef enum logic [1:0] {
        CLS_NONE    = 2'd0,
        CLS_BLANK   = 2'd1,
        CLS_CODE    = 2'd2,
        CLS_COMMENT = 2'd3
    } cls_t;

    // Event passed from the lexer to the counters
    typedef struct packed {
        logic eof;
        cls_t cls;
    } evt_t;

endpackage

// ===== src/slc_lexer.sv =====
// Front end: accepts source bytes and end-of-file items, tracks lexical mode.
// Emits one event per newline or end of file. Depends on slc_pkg.
module slc_lexer
    import slc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    input  logic                  in_opcode,
    input  logic [BYTE_WIDTH-1:0] in_byte,
    output logic                  in_ready,
    output logic                  evt_valid,
    output evt_t                  evt,
    input  logic                  evt_ready
);

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_STRING = 2'd1,
        MODE_CHAR   = 2'd2,
        MODE_BLOCK  = 2'd3
    } mode_t;

    mode_t mode_reg, mode_next;
    logic  esc_reg, esc_next;
    logic  star_reg, star_next;
    logic  slash_reg, slash_next;
    logic  lcom_reg, lcom_next;
    logic  code_reg, code_next;
    logic  com_reg, com_next;
    logic  text_reg, text_next;

    logic  accept;
    logic  is_nl;
    logic  ws;
    cls_t  close_cls;

    function automatic logic is_ws(input logic [BYTE_WIDTH-1:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL) ||
               (c == CH_CR) || (c == CH_VT) || (c == CH_FF);
    endfunction

    assign in_ready  = evt_ready;
    assign accept    = in_valid && in_ready;
    assign is_nl     = (in_byte == CH_NL);
    assign ws        = is_ws(in_byte);
    assign evt_valid = accept && ((in_opcode == OP_EOF) || is_nl);

    // Class of the line being closed; a pending lone slash counts as code
    always_comb begin
        if (!text_reg) begin
            close_cls = CLS_BLANK;
        end else if (code_reg || slash_reg) begin
            close_cls = CLS_CODE;
        end else if (com_reg) begin
            close_cls = CLS_COMMENT;
        end else begin
            close_cls = CLS_NONE;
        end
    end

    assign evt.eof = (in_opcode == OP_EOF);
    assign evt.cls = close_cls;

    always_comb begin
        mode_next  = mode_reg;
        esc_next   = esc_reg;
        star_next  = star_reg;
        slash_next = slash_reg;
        lcom_next  = lcom_reg;
        code_next  = code_reg;
        com_next   = com_reg;
        text_next  = text_reg;
        if (accept) begin
            if (in_opcode == OP_EOF) begin
                // end of file: drop all line and mode state
                mode_next  = MODE_NORMAL;
                esc_next   = 1'b0;
                star_next  = 1'b0;
                slash_next = 1'b0;
                lcom_next  = 1'b0;
                code_next  = 1'b0;
                com_next   = 1'b0;
                text_next  = 1'b0;
            end else if (is_nl) begin
                // mode carries over; a line starting in a literal is code
                esc_next   = 1'b0;
                star_next  = 1'b0;
                slash_next = 1'b0;
                lcom_next  = 1'b0;
                text_next  = 1'b0;
                code_next  = (mode_reg == MODE_STRING) || (mode_reg == MODE_CHAR);
                com_next   = (mode_reg == MODE_BLOCK);
            end else begin
                if (!ws) begin
                    text_next = 1'b1;
                end
                unique case (mode_reg)
                    MODE_STRING, MODE_CHAR: begin
                        if (esc_reg) begin
                            esc_next = 1'b0;
                        end else if (in_byte == CH_BSLASH) begin
                            esc_next = 1'b1;
                        end else if ((mode_reg == MODE_STRING && in_byte == CH_QUOTE) ||
                                     (mode_reg == MODE_CHAR && in_byte == CH_APOS)) begin
                            mode_next = MODE_NORMAL;
                        end
                    end
                    MODE_BLOCK: begin
                        if (star_reg && in_byte == CH_SLASH) begin
                            mode_next = MODE_NORMAL;
                            star_next = 1'b0;
                        end else begin
                            star_next = (in_byte == CH_STAR);
                        end
                    end
                    MODE_NORMAL: begin
                        if (!lcom_reg) begin
                            if (slash_reg && in_byte == CH_STAR) begin
                                slash_next = 1'b0;
                                com_next   = 1'b1;
                                mode_next  = MODE_BLOCK;
                                star_next  = 1'b0;
                            end else if (slash_reg && in_byte == CH_SLASH) begin
                                slash_next = 1'b0;
                                com_next   = 1'b1;
                                lcom_next  = 1'b1;
                            end else begin
                                slash_next = 1'b0;
                                if (slash_reg) begin
                                    code_next = 1'b1;
                                end
                                priority if (in_byte == CH_QUOTE) begin
                                    code_next = 1'b1;
                                    mode_next = MODE_STRING;
                                    esc_next  = 1'b0;
                                end else if (in_byte == CH_APOS) begin
                                    code_next = 1'b1;
                                    mode_next = MODE_CHAR;
                                    esc_next  = 1'b0;
                                end else if (in_byte == CH_SLASH) begin
                                    slash_next = 1'b1;
                                end else if (!ws) begin
                                    code_next = 1'b1;
                                end
                            end
                        end
                    end
                    default: begin
                        mode_next = mode_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_NORMAL;
            esc_reg   <= 1'b0;
            star_reg  <= 1'b0;
            slash_reg <= 1'b0;
            lcom_reg  <= 1'b0;
            code_reg  <= 1'b0;
            com_reg   <= 1'b0;
            text_reg  <= 1'b0;
        end else begin
            mode_reg  <= mode_next;
            esc_reg   <= esc_next;
            star_reg  <= star_next;
            slash_reg <= slash_next;
            lcom_reg  <= lcom_next;
            code_reg  <= code_next;
            com_reg   <= com_next;
            text_reg  <= text_next;
        end
    end

endmodule

// ===== src/slc_queue.sv =====
// Short event queue between the lexer and the counters.
// Depends on slc_pkg for the event type.
module slc_queue
    import slc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  evt_t push_evt,
    output logic not_full,
    output logic head_valid,
    output evt_t head_evt,
    input  logic pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    evt_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign not_full   = (count_reg != FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_evt   = slot_reg[rd_ptr_reg];
    assign do_push    = push && not_full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_evt;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_CNT)
        else $error("queue count beyond depth");

endmodule

// ===== src/slc_counter.sv =====
// Back end: applies line events to saturating counters, emits totals at end
// of file through an output register. Depends on slc_pkg.
module slc_counter
    import slc_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            head_valid,
    input  evt_t                            head_evt,
    output logic                            pop,
    output logic                            out_valid,
    output logic [OUT_FIELDS*OUT_WIDTH-1:0] out_data,
    input  logic                            out_ready
);

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    logic [COUNT_WIDTH-1:0] fcode_reg, fblank_reg, fcom_reg;
    logic [COUNT_WIDTH-1:0] tcode_reg, tblank_reg, tcom_reg;
    logic [COUNT_WIDTH-1:0] files_reg;
    logic [COUNT_WIDTH-1:0] fcode_next, fblank_next, fcom_next;
    logic [COUNT_WIDTH-1:0] tcode_next, tblank_next, tcom_next;
    logic [COUNT_WIDTH-1:0] files_next;
    logic                   out_valid_reg;
    logic [OUT_FIELDS*OUT_WIDTH-1:0] out_data_reg;
    logic                   out_free;
    logic                   pop_eof;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v,
                                                       input logic en);
        return (en && v != CNT_MAX) ? v + COUNT_WIDTH'(1) : v;
    endfunction

    // hold an end-of-file event while the previous result waits
    assign out_free  = !out_valid_reg || out_ready;
    assign pop       = head_valid && (!head_evt.eof || out_free);
    assign pop_eof   = pop && head_evt.eof;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb begin
        fcode_next  = sat_inc(fcode_reg,  head_evt.cls == CLS_CODE);
        fblank_next = sat_inc(fblank_reg, head_evt.cls == CLS_BLANK);
        fcom_next   = sat_inc(fcom_reg,   head_evt.cls == CLS_COMMENT);
        tcode_next  = sat_inc(tcode_reg,  head_evt.cls == CLS_CODE);
        tblank_next = sat_inc(tblank_reg, head_evt.cls == CLS_BLANK);
        tcom_next   = sat_inc(tcom_reg,   head_evt.cls == CLS_COMMENT);
        files_next  = sat_inc(files_reg,  head_evt.eof);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fcode_reg     <= '0;
            fblank_reg    <= '0;
            fcom_reg      <= '0;
            tcode_reg     <= '0;
            tblank_reg    <= '0;
            tcom_reg      <= '0;
            files_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                tcode_reg  <= tcode_next;
                tblank_reg <= tblank_next;
                tcom_reg   <= tcom_next;
                files_reg  <= files_next;
                if (head_evt.eof) begin
                    fcode_reg  <= '0;
                    fblank_reg <= '0;
                    fcom_reg   <= '0;
                end else begin
                    fcode_reg  <= fcode_next;
                    fblank_reg <= fblank_next;
                    fcom_reg   <= fcom_next;
                end
            end
            if (pop_eof) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop_eof) begin
            out_data_reg <= {OUT_WIDTH'(files_next),
                             OUT_WIDTH'(tcom_next),
                             OUT_WIDTH'(tblank_next),
                             OUT_WIDTH'(tcode_next),
                             OUT_WIDTH'(fcom_next),
                             OUT_WIDTH'(fblank_next),
                             OUT_WIDTH'(fcode_next)};
        end
    end

    a_eof_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        pop_eof |=> out_valid_reg)
        else $error("end of file popped without a result");

    a_files_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        pop_eof |=> (files_reg != '0))
        else $error("file counter zero after end of file");

    a_totals_cover_file: assert property (@(posedge aclk) disable iff (!aresetn)
        (tcode_reg >= fcode_reg) && (tblank_reg >= fblank_reg) && (tcom_reg >= fcom_reg))
        else $error("running total below per-file count");

endmodule

// ===== src/source_line_classifier.sv =====
// Source line classifier: counts C source lines as code, blank or comment.
// An end-of-file item reaches m_tvalid through the event queue and output register.
// Throughput: one item per cycle unless s_tready drops; lexer mode loop is registered.
// s_tready drops only when the event queue fills, i.e. when results back up.
// Reset: synchronous, active low; clears mode, line flags, queue and all counters.
module source_line_classifier
    import slc_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [BYTE_WIDTH-1:0]           s_tdata,  // [7:0] source_byte
    input  logic [0:0]                      s_tuser,  // [0] opcode
    // result items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [31:0] file_code_lines, [63:32] file_blank_lines,
    // [95:64] file_comment_lines, [127:96] total_code_lines,
    // [159:128] total_blank_lines, [191:160] total_comment_lines,
    // [223:192] files_done
    output logic [OUT_FIELDS*OUT_WIDTH-1:0] m_tdata
);

    // Front: lexer turns bytes into line events (newline, end of file)
    logic evt_valid;
    evt_t evt;
    logic q_not_full;

    // Back: counters pull events from the queue head
    logic q_head_valid;
    evt_t q_head_evt;
    logic q_pop;

    slc_lexer u_lexer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_opcode (s_tuser[0]),
        .in_byte   (s_tdata),
        .in_ready  (s_tready),
        .evt_valid (evt_valid),
        .evt       (evt),
        .evt_ready (q_not_full)
    );

    // Decouple lexer from counters; a stalled result blocks bytes only on a full queue
    slc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (evt_valid),
        .push_evt   (evt),
        .not_full   (q_not_full),
        .head_valid (q_head_valid),
        .head_evt   (q_head_evt),
        .pop        (q_pop)
    );

    // Saturating counters and the result register
    slc_counter #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_counter (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_head_valid),
        .head_evt   (q_head_evt),
        .pop        (q_pop),
        .out_valid  (m_tvalid),
        .out_data   (m_tdata),
        .out_ready  (m_tready)
    );

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for source_line_classifier (uses slc_pkg): random C-like
// byte streams with end-of-file items, checked against a built-in line classifier.
`timescale 1ns / 1ps

module testbench;
    import slc_pkg::*;

    localparam int RESET_CYCLES = 5;
    localparam int DRAIN_CYCLES = 10;    // margin after the last owed result
    localparam int STALL_LIMIT  = 2000;  // cycles with no item moving on either side
    localparam int PHASE_ITEMS  = 462;   // random items per handshake phase

    // Lexer modes of the predictor
    typedef enum logic [1:0] {
        LEX_NORMAL = 2'd0,
        LEX_STRING = 2'd1,
        LEX_CHAR   = 2'd2,
        LEX_BLOCK  = 2'd3
    } lex_mode_t;

    // One input item as it travels on s_tdata / s_tuser
    typedef struct {
        logic            op;
        logic [BYTE_WIDTH-1:0] data;
    } src_item_t;

    // One result item; the last field sits in the lowest bits of m_tdata
    typedef struct packed {
        logic [OUT_WIDTH-1:0] files_done;
        logic [OUT_WIDTH-1:0] total_comment;
        logic [OUT_WIDTH-1:0] total_blank;
        logic [OUT_WIDTH-1:0] total_code;
        logic [OUT_WIDTH-1:0] file_comment;
        logic [OUT_WIDTH-1:0] file_blank;
        logic [OUT_WIDTH-1:0] file_code;
    } line_totals_t;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [BYTE_WIDTH-1:0]         s_tdata  = '0;   // [7:0] source_byte
    logic [0:0]                    s_tuser  = '0;   // [0] opcode
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [OUT_FIELDS*OUT_WIDTH-1:0] m_tdata;       // line_totals_t, file_code lowest

    source_line_classifier u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    src_item_t    pending_items[$];   // items waiting for the driver
    line_totals_t expected_totals[$]; // results owed by the block, oldest first
    src_item_t    next_item;

    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned mismatch_count = 0;
    int unsigned items_sent     = 0;
    int unsigned files_sent     = 0;
    int unsigned totals_checked = 0;
    int unsigned quiet_cycles   = 0;

    // ------------------------------------------------------------------
    // Line classifier predictor: its own copy of the lexer and counters
    // ------------------------------------------------------------------
    lex_mode_t            lex_mode;
    logic                 esc_q, star_q, slash_q, in_line_cmt;
    logic                 ln_code, ln_comment, ln_text;
    logic [OUT_WIDTH-1:0] n_file_code, n_file_blank, n_file_comment;
    logic [OUT_WIDTH-1:0] n_total_code, n_total_blank, n_total_comment;
    logic [OUT_WIDTH-1:0] n_files;

    // Hold a counter at its maximum instead of wrapping
    function automatic logic [OUT_WIDTH-1:0] bump(input logic [OUT_WIDTH-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic bit is_space(input logic [BYTE_WIDTH-1:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_CR ||
               c == CH_VT || c == CH_FF;
    endfunction

    task automatic clear_lexer();
        lex_mode    = LEX_NORMAL;
        esc_q       = 1'b0;
        star_q      = 1'b0;
        slash_q     = 1'b0;
        in_line_cmt = 1'b0;
        ln_code     = 1'b0;
        ln_comment  = 1'b0;
        ln_text     = 1'b0;
    endtask

    // Classify the line just ended, then seed the flags of the next one
    task automatic finish_line();
        if (slash_q)
            ln_code = 1'b1;   // a lone slash is code, even at the end of a line
        if (!ln_text) begin
            n_file_blank  = bump(n_file_blank);
            n_total_blank = bump(n_total_blank);
        end else if (ln_code) begin
            n_file_code  = bump(n_file_code);
            n_total_code = bump(n_total_code);
        end else if (ln_comment) begin
            n_file_comment  = bump(n_file_comment);
            n_total_comment = bump(n_total_comment);
        end
        esc_q       = 1'b0;
        star_q      = 1'b0;
        slash_q     = 1'b0;
        in_line_cmt = 1'b0;
        ln_text     = 1'b0;
        // the mode carries over, so a line opened inside a literal is code
        ln_code     = (lex_mode == LEX_STRING || lex_mode == LEX_CHAR);
        ln_comment  = (lex_mode == LEX_BLOCK);
    endtask

    task automatic scan_normal(input logic [BYTE_WIDTH-1:0] c);
        if (in_line_cmt)
            return;
        if (slash_q) begin
            slash_q = 1'b0;
            if (c == CH_STAR) begin
                ln_comment = 1'b1;
                lex_mode   = LEX_BLOCK;
                star_q     = 1'b0;   // the opening star cannot close the comment
                return;
            end
            if (c == CH_SLASH) begin
                ln_comment  = 1'b1;
                in_line_cmt = 1'b1;
                return;
            end
            ln_code = 1'b1;
        end
        if (c == CH_QUOTE) begin
            ln_code  = 1'b1;
            lex_mode = LEX_STRING;
            esc_q    = 1'b0;
        end else if (c == CH_APOS) begin
            ln_code  = 1'b1;
            lex_mode = LEX_CHAR;
            esc_q    = 1'b0;
        end else if (c == CH_SLASH) begin
            slash_q = 1'b1;
        end else if (!is_space(c)) begin
            ln_code = 1'b1;
        end
    endtask

    task automatic scan_byte(input logic [BYTE_WIDTH-1:0] c);
        if (c == CH_NL) begin
            finish_line();
            return;
        end
        if (!is_space(c))
            ln_text = 1'b1;
        case (lex_mode)
            LEX_STRING, LEX_CHAR: begin
                if (esc_q)
                    esc_q = 1'b0;
                else if (c == CH_BSLASH)
                    esc_q = 1'b1;
                else if (c == ((lex_mode == LEX_STRING) ? CH_QUOTE : CH_APOS))
                    lex_mode = LEX_NORMAL;
            end
            LEX_BLOCK: begin
                if (star_q && c == CH_SLASH) begin
                    lex_mode = LEX_NORMAL;
                    star_q   = 1'b0;
                end else begin
                    star_q = (c == CH_STAR);
                end
            end
            default: scan_normal(c);
        endcase
    endtask

    // Advance the predictor by one accepted item; queue a result on end of file
    task automatic predict_item(input logic op, input logic [BYTE_WIDTH-1:0] c);
        line_totals_t t;
        if (op == OP_BYTE) begin
            scan_byte(c);
            return;
        end
        finish_line();
        n_files         = bump(n_files);
        t.file_code     = n_file_code;
        t.file_blank    = n_file_blank;
        t.file_comment  = n_file_comment;
        t.total_code    = n_total_code;
        t.total_blank   = n_total_blank;
        t.total_comment = n_total_comment;
        t.files_done    = n_files;
        expected_totals.push_back(t);
        n_file_code    = '0;
        n_file_blank   = '0;
        n_file_comment = '0;
        clear_lexer();
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_byte(input logic [BYTE_WIDTH-1:0] c);
        src_item_t it;
        it.op   = OP_BYTE;
        it.data = c;
        pending_items.push_back(it);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    // The byte lane is ignored at end of file: fill it with noise
    task automatic push_eof();
        src_item_t it;
        it.op   = OP_EOF;
        it.data = BYTE_WIDTH'($urandom);
        pending_items.push_back(it);
        files_sent++;
    endtask

    function automatic logic [BYTE_WIDTH-1:0] pick_space();
        case ($urandom_range(4))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_CR;
            3: return CH_VT;
            default: return CH_FF;
        endcase
    endfunction

    function automatic logic [BYTE_WIDTH-1:0] pick_text();
        return BYTE_WIDTH'($urandom_range(8'h7E, 8'h20));
    endfunction

    task automatic push_word();
        for (int i = $urandom_range(5, 1); i > 0; i--)
            push_byte(BYTE_WIDTH'($urandom_range(8'h7A, 8'h61)));
    endtask

    task automatic push_filler(input int max_len);
        for (int i = $urandom_range(max_len); i > 0; i--)
            push_byte(pick_text());
    endtask

    // Emit one line shaped like C source: mostly well formed, some noise
    task automatic push_line(input bit with_nl);
        case ($urandom_range(7))
            0: for (int i = $urandom_range(3); i > 0; i--)
                   push_byte(pick_space());
            1: begin
                push_word();
                push_byte(pick_space());
                push_text("= ");
                push_word();
                push_byte(";");
            end
            2: begin
                push_word();
                push_byte(CH_QUOTE);
                for (int i = $urandom_range(6); i > 0; i--) begin
                    if ($urandom_range(3) == 0)
                        push_byte(CH_BSLASH);
                    push_byte(pick_text());
                end
                if ($urandom_range(4) != 0)
                    push_byte(CH_QUOTE);   // sometimes leave the string open
            end
            3: begin
                push_byte(CH_APOS);
                if ($urandom_range(1))
                    push_byte(CH_BSLASH);
                push_byte(pick_text());
                push_byte(CH_APOS);
            end
            4: begin
                if ($urandom_range(1))
                    push_word();
                push_byte(CH_SLASH);
                push_byte(CH_SLASH);
                push_filler(8);
            end
            5: begin
                if ($urandom_range(3) == 0)
                    push_word();
                push_byte(CH_SLASH);
                push_byte(CH_STAR);
                push_filler(8);
            end
            6: begin
                push_filler(6);
                push_byte(CH_STAR);
                push_byte(CH_SLASH);
                if ($urandom_range(1))
                    push_word();
            end
            default: for (int i = $urandom_range(6, 1); i > 0; i--)
                         push_byte(BYTE_WIDTH'($urandom_range(255)));
        endcase
        if (with_nl)
            push_byte(CH_NL);
    endtask

    // A file of a few lines; the last line may end at the end of file itself
    task automatic push_file();
        int lines;
        lines = $urandom_range(6);
        for (int i = 0; i < lines; i++)
            push_line(i < lines - 1 || $urandom_range(9) >= 3);
        push_eof();
    endtask

    task automatic push_directed();
        // whitespace-only line is blank
        push_byte(CH_SPACE);
        push_byte(CH_TAB);
        push_byte(CH_CR);
        push_byte(CH_VT);
        push_byte(CH_FF);
        push_byte(CH_NL);
        // line comment swallows the top byte, then a NUL byte counts as code
        push_byte(CH_SLASH);
        push_byte(CH_SLASH);
        push_byte(8'hFF);
        push_byte(CH_NL);
        push_byte(8'h00);
        push_byte(CH_NL);
        // slash-star-slash stays open; the byte after the closing pair is code
        push_text("/*/");
        push_byte(CH_NL);
        push_text("*/x");
        push_eof();
        // escaped quote keeps the string open across the newline, so the
        // next line is code; a lone slash then meets the end of file
        push_byte(CH_QUOTE);
        push_byte(CH_BSLASH);
        push_byte(CH_QUOTE);
        push_byte(CH_NL);
        push_byte(CH_QUOTE);
        push_byte(CH_SLASH);
        push_eof();
        // empty file: its single empty line still counts as blank
        push_eof();
    endtask

    // ------------------------------------------------------------------
    // Driver: present queued items, predict each one as it is accepted
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_item(s_tuser[0], s_tdata);
                items_sent++;
            end
            // advance only when the lane is free or its item was just taken
            if (!s_tvalid || s_tready) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                    next_item = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_item.data;
                    s_tuser  <= next_item.op;
                end else begin
                    s_tvalid <= 1'b0;
                    s_tdata  <= BYTE_WIDTH'($urandom);
                    s_tuser  <= 1'($urandom);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each result with the oldest expectation
    // ------------------------------------------------------------------
    function automatic void check_field(input string name,
                                        input logic [OUT_WIDTH-1:0] want,
                                        input logic [OUT_WIDTH-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    line_totals_t got_totals, want_totals;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_totals = line_totals_t'(m_tdata);
                if (expected_totals.size() == 0) begin
                    $display("%0t: unexpected result, expected none got %h",
                             $time, m_tdata);
                    mismatch_count++;
                end else begin
                    want_totals = expected_totals.pop_front();
                    check_field("file_code_lines", want_totals.file_code,
                                got_totals.file_code);
                    check_field("file_blank_lines", want_totals.file_blank,
                                got_totals.file_blank);
                    check_field("file_comment_lines", want_totals.file_comment,
                                got_totals.file_comment);
                    check_field("total_code_lines", want_totals.total_code,
                                got_totals.total_code);
                    check_field("total_blank_lines", want_totals.total_blank,
                                got_totals.total_blank);
                    check_field("total_comment_lines", want_totals.total_comment,
                                got_totals.total_comment);
                    check_field("files_done", want_totals.files_done,
                                got_totals.files_done);
                    totals_checked++;
                end
            end
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Watchdog: drop the run when no item moves for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: watchdog expired, %0d results still owed",
                         $time, expected_totals.size());
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: reset once, then run the handshake phases
    // ------------------------------------------------------------------
    int unsigned phase_idle[4]  = '{0, 74, 0, 30};
    int unsigned phase_stall[4] = '{0, 0, 74, 30};

    initial begin
        int unsigned target;
        clear_lexer();
        n_file_code     = '0;
        n_file_blank    = '0;
        n_file_comment  = '0;
        n_total_code    = '0;
        n_total_blank   = '0;
        n_total_comment = '0;
        n_files         = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        for (int ph = 0; ph < 4; ph++) begin
            // hold the sender until every owed result is back, then switch pressure;
            // sample on the falling edge so the driver's updates have settled
            while (pending_items.size() > 0 || s_tvalid || expected_totals.size() > 0)
                @(negedge aclk);
            src_idle_pct   = phase_idle[ph];
            sink_stall_pct = phase_stall[ph];
            if (ph == 0)
                push_directed();
            target = pending_items.size() + PHASE_ITEMS;
            while (pending_items.size() < target)
                push_file();
        end

        // wait for the last item and every owed result, then let the pipe drain
        @(negedge aclk);
        while (pending_items.size() > 0 || s_tvalid || expected_totals.size() > 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d items in %0d files over four pressure phases",
                 items_sent, files_sent);
        $display("checked %0d result items, %0d field mismatches",
                 totals_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
src/slc_pkg.sv
src/slc_lexer.sv
src/slc_queue.sv
src/slc_counter.sv
src/source_line_classifier.sv
tb/sv/testbench.sv
